/* sv/goldbach_pair_search_top_assert.svh */
// assertion macros for the goldbach pair search block
// used by goldbach_pair_search_top; expects clk_i and rst_ni in scope
`ifndef GOLDBACH_PAIR_SEARCH_TOP_ASSERT_SVH
`define GOLDBACH_PAIR_SEARCH_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/gps_pkg.sv */
// shared types and constants of the goldbach pair search block
// no dependencies
package gps_pkg;

  // fixed width of the value fields and of the counters
  localparam int FIELD_BITS = 16;
  localparam int COUNT_BITS = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // register indexes, decoded from paddr[2]
  localparam logic REG_WINDOW_LOW  = 1'b0;
  localparam logic REG_WINDOW_HIGH = 1'b1;

  // search sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_PINIT,
    S_PSQ,
    S_PDIV,
    S_FIN
  } ctrl_state_e;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic                  found;
    logic [FIELD_BITS-1:0] first_prime;
    logic [FIELD_BITS-1:0] second_prime;
  } result_t;

endpackage

/* sv/goldbach_pair_search_top.sv */
// channel  | handshake                      | payload
// in       | in_valid_i / in_stall_o        | test_value_i
// out      | out_valid_o / out_stall_i      | found_o, first_prime_o, second_prime_o, totals
// cfg      | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// one word at a time; the search sequencer and its shared remainder unit do the search
// each candidate in the window is checked, then both members are tested by trial division
// reset: window low = 2, window high = all ones, counters zero, no clearing pass
// a result waits in the output register while the next word is searched
// in_stall_o is high while a search runs; the sequencer holds a result until loaded
//
// top level of the goldbach pair search block
// uses gps_pkg, gps_ctrl (with gps_rem) and goldbach_pair_search_top_assert.svh
module goldbach_pair_search_top #(
  parameter int VALUE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gps_pkg::FIELD_BITS-1:0]  test_value_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [gps_pkg::FIELD_BITS-1:0]  first_prime_o,
  output logic [gps_pkg::FIELD_BITS-1:0]  second_prime_o,
  output logic [gps_pkg::COUNT_BITS-1:0]  tested_total_o,
  output logic [gps_pkg::COUNT_BITS-1:0]  success_total_o,
  output logic [gps_pkg::COUNT_BITS-1:0]  failure_total_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import gps_pkg::*;

  `include "goldbach_pair_search_top_assert.svh"

  localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

  logic [VW-1:0]         win_low_q;
  logic [VW-1:0]         win_high_q;
  logic [COUNT_BITS-1:0] tested_q, success_q, failure_q;
  logic                  out_valid_q;
  result_t               out_res_q;
  result_t               res;
  logic                  busy;
  logic                  done;
  logic                  load;
  logic                  in_accept;
  logic                  cfg_write;

  assign in_accept = in_valid_i && !busy;
  assign load      = done && (!out_valid_q || !out_stall_i);
  assign cfg_write = psel && penable && pwrite && pready;

  gps_ctrl #(.VW(VW)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .value_i (test_value_i[VW-1:0]),
    .lo_i    (win_low_q),
    .hi_i    (win_high_q),
    .ack_i   (load),
    .busy_o  (busy),
    .done_o  (done),
    .res_o   (res)
  );

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low_q  <= VW'(2);
      win_high_q <= '1;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_WINDOW_LOW:  win_low_q  <= pwdata[VW-1:0];
        REG_WINDOW_HIGH: win_high_q <= pwdata[VW-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LOW:  prdata = 32'(win_low_q);
      REG_WINDOW_HIGH: prdata = 32'(win_high_q);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // saturating item counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tested_q  <= '0;
      success_q <= '0;
      failure_q <= '0;
    end else if (load) begin
      if (tested_q != COUNT_MAX) tested_q <= tested_q + 1'b1;
      if (res.found) begin
        if (success_q != COUNT_MAX) success_q <= success_q + 1'b1;
      end else begin
        if (failure_q != COUNT_MAX) failure_q <= failure_q + 1'b1;
      end
    end
  end

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q <= res;
    end
  end

  assign in_stall_o      = busy;
  assign out_valid_o     = out_valid_q;
  assign found_o         = out_res_q.found;
  assign first_prime_o   = out_res_q.first_prime;
  assign second_prime_o  = out_res_q.second_prime;
  assign tested_total_o  = tested_q;
  assign success_total_o = success_q;
  assign failure_total_o = failure_q;

  // checks
  `GPS_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall_o,
                   "search not busy after accepting a word")
  `GPS_ASSERT_NOW(a_counts_bounded, 1'b1, tested_q >= success_q && tested_q >= failure_q,
                  "success or failure count above tested count")
  `GPS_ASSERT_NOW(a_miss_zeroes, out_valid_o && !found_o,
                  first_prime_o == '0 && second_prime_o == '0,
                  "result without a pair carries nonzero primes")
  `GPS_ASSERT_NEXT(a_load_sets_valid, load, out_valid_o,
                   "loaded result not presented")

endmodule

/* sv/gps_rem.sv */
// iterative restoring remainder unit, one quotient bit per cycle
// uses gps_pkg; instantiated by gps_ctrl
module gps_rem #(
  parameter int VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [VW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic          zero_o
);
  import gps_pkg::*;

  localparam int CW = (VW > 1) ? $clog2(VW) : 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] num_q, num_d;
  logic [VW-1:0] div_q, div_d;
  logic [VW:0]   rem_q, rem_d;
  logic [VW:0]   shifted;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    div_d   = div_q;
    rem_d   = rem_q;
    shifted = {rem_q[VW-1:0], num_q[VW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(VW - 1);
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (shifted >= {1'b0, div_q}) ? shifted - {1'b0, div_q} : shifted;
      num_d = {num_q[VW-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign zero_o = (rem_q == '0);

endmodule

/* sv/gps_ctrl.sv */
// search sequencer: candidate sweep and trial-division primality test
// uses gps_pkg and the shared remainder unit gps_rem
module gps_ctrl #(
  parameter int VW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VW-1:0]    value_i,
  input  logic [VW-1:0]    lo_i,
  input  logic [VW-1:0]    hi_i,
  input  logic             ack_i,
  output logic             busy_o,
  output logic             done_o,
  output gps_pkg::result_t res_o
);
  import gps_pkg::*;

  ctrl_state_e   state_q, state_d;
  logic [VW-1:0] t_q, t_d;
  logic [VW-1:0] top_q, top_d;
  logic [VW:0]   p1_q, p1_d;
  logic [VW-1:0] p2_q, p2_d;
  logic [VW-1:0] v_q, v_d;
  logic          second_q, second_d;
  logic [VW-1:0] d_q, d_d;
  logic [VW:0]   sq_q, sq_d;
  logic          hit_q, hit_d;
  logic [VW-1:0] p2_calc;
  logic          rem_start;
  logic          rem_done;
  logic          rem_zero;

  gps_rem #(.VW(VW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (v_q),
    .divisor_i  (d_q),
    .done_o     (rem_done),
    .zero_o     (rem_zero)
  );

  assign p2_calc = t_q - p1_q[VW-1:0];

  // next state and datapath updates
  always_comb begin
    state_d   = state_q;
    t_d       = t_q;
    top_d     = top_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    v_d       = v_q;
    second_d  = second_q;
    d_d       = d_q;
    sq_d      = sq_q;
    hit_d     = hit_q;
    rem_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          t_d     = value_i;
          top_d   = (hi_i < value_i) ? hi_i : value_i;
          p1_d    = {1'b0, lo_i};
          hit_d   = 1'b0;
          state_d = S_CAND;
        end
      end
      // candidate bound and partner window check
      S_CAND: begin
        if (p1_q > {1'b0, top_q}) begin
          hit_d   = 1'b0;
          state_d = S_FIN;
        end else if (p2_calc < lo_i || p2_calc > hi_i) begin
          p1_d = p1_q + 1'b1;
        end else begin
          p2_d     = p2_calc;
          v_d      = p1_q[VW-1:0];
          second_d = 1'b0;
          state_d  = S_PINIT;
        end
      end
      // values below two are not prime
      S_PINIT: begin
        if (v_q < VW'(2)) begin
          p1_d    = p1_q + 1'b1;
          state_d = S_CAND;
        end else begin
          d_d     = VW'(2);
          sq_d    = (VW+1)'(4);
          state_d = S_PSQ;
        end
      end
      // divisor squared past the value: prime, else start a division
      S_PSQ: begin
        if (sq_q > {1'b0, v_q}) begin
          if (!second_q) begin
            v_d      = p2_q;
            second_d = 1'b1;
            state_d  = S_PINIT;
          end else begin
            hit_d   = 1'b1;
            state_d = S_FIN;
          end
        end else begin
          rem_start = 1'b1;
          state_d   = S_PDIV;
        end
      end
      // wait for the remainder: next divisor on a nonzero one, next candidate on zero
      S_PDIV: begin
        if (rem_done) begin
          if (rem_zero) begin
            p1_d    = p1_q + 1'b1;
            state_d = S_CAND;
          end else begin
            d_d     = d_q + 1'b1;
            sq_d    = sq_q + {d_q, 1'b1};
            state_d = S_PSQ;
          end
        end
      end
      S_FIN: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search registers
  always_ff @(posedge clk_i) begin
    t_q      <= t_d;
    top_q    <= top_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    v_q      <= v_d;
    second_q <= second_d;
    d_q      <= d_d;
    sq_q     <= sq_d;
    hit_q    <= hit_d;
  end

  // result word, zeros when no pair
  always_comb begin
    res_o.found        = hit_q;
    res_o.first_prime  = hit_q ? FIELD_BITS'(p1_q[VW-1:0]) : '0;
    res_o.second_prime = hit_q ? FIELD_BITS'(p2_q) : '0;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_FIN);

endmodule

/* dv/gps_result_checker.sv */
// result checker for the goldbach pair search block
// watches the test value, result and configuration ports; predicts each result word
// depends on gps_pkg
module gps_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // test value channel
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [gps_pkg::FIELD_BITS-1:0]  test_value_i,
  // result channel
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            found_i,
  input  logic [gps_pkg::FIELD_BITS-1:0]  first_prime_i,
  input  logic [gps_pkg::FIELD_BITS-1:0]  second_prime_i,
  input  logic [gps_pkg::COUNT_BITS-1:0]  tested_total_i,
  input  logic [gps_pkg::COUNT_BITS-1:0]  success_total_i,
  input  logic [gps_pkg::COUNT_BITS-1:0]  failure_total_i,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  input  logic [31:0]                     prdata,
  input  logic                            pready,
  // status toward the testbench top
  output int unsigned                     mismatch_cnt_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gps_pkg::*;

  // one predicted result word: the pair and the running totals after it
  typedef struct packed {
    result_t               pair;
    logic [COUNT_BITS-1:0] tested;
    logic [COUNT_BITS-1:0] success;
    logic [COUNT_BITS-1:0] failure;
  } search_word_t;

  search_word_t          pending_words_q[$];
  search_word_t          oldest;
  search_word_t          fresh;
  logic [FIELD_BITS-1:0] win_lo;
  logic [FIELD_BITS-1:0] win_hi;
  logic [FIELD_BITS-1:0] read_want;
  logic [COUNT_BITS-1:0] tested_cnt;
  logic [COUNT_BITS-1:0] success_cnt;
  logic [COUNT_BITS-1:0] failure_cnt;
  int unsigned           errors;

  // trial division by every d with d*d <= v
  function automatic bit prime_by_division(input int unsigned v);
    int unsigned d;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // smallest p1 with p1 and t - p1 both window primes
  function automatic result_t find_pair(input logic [FIELD_BITS-1:0] t,
                                        input logic [FIELD_BITS-1:0] lo,
                                        input logic [FIELD_BITS-1:0] hi);
    int unsigned p1;
    int unsigned p2;
    int unsigned last;
    result_t     r;
    r = '0;
    last = (hi > t) ? t : hi;
    for (p1 = lo; p1 <= last; p1++) begin
      p2 = t - p1;
      if (p2 >= lo && p2 <= hi) begin
        if (prime_by_division(p1) && prime_by_division(p2)) begin
          r.found        = 1'b1;
          r.first_prime  = p1[FIELD_BITS-1:0];
          r.second_prime = p2[FIELD_BITS-1:0];
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo = 16'd2;
      win_hi = 16'hFFFF;
      tested_cnt = '0;
      success_cnt = '0;
      failure_cnt = '0;
      pending_words_q.delete();
      errors = 0;
      mismatch_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // result word against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (pending_words_q.size() == 0) begin
          errors++;
          $error("result word with no test value pending");
        end else begin
          oldest = pending_words_q.pop_front();
          check_field("found", oldest.pair.found, found_i);
          check_field("first_prime", oldest.pair.first_prime, first_prime_i);
          check_field("second_prime", oldest.pair.second_prime, second_prime_i);
          check_field("tested_total", oldest.tested, tested_total_i);
          check_field("success_total", oldest.success, success_total_i);
          check_field("failure_total", oldest.failure, failure_total_i);
        end
      end
      // register write
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WINDOW_HIGH) begin
          win_hi = pwdata[FIELD_BITS-1:0];
        end else begin
          win_lo = pwdata[FIELD_BITS-1:0];
        end
      end
      // register readback
      if (psel && penable && !pwrite && pready) begin
        read_want = (paddr[2] == REG_WINDOW_HIGH) ? win_hi : win_lo;
        check_field("prdata", {16'd0, read_want}, prdata);
      end
      // accepted test value word: predict its result
      if (in_valid_i && !in_stall_i) begin
        fresh.pair = find_pair(test_value_i, win_lo, win_hi);
        tested_cnt = sat_inc(tested_cnt);
        if (fresh.pair.found) begin
          success_cnt = sat_inc(success_cnt);
        end else begin
          failure_cnt = sat_inc(failure_cnt);
        end
        fresh.tested  = tested_cnt;
        fresh.success = success_cnt;
        fresh.failure = failure_cnt;
        pending_words_q = {pending_words_q, fresh};
      end
      mismatch_cnt_o <= errors;
      pending_o <= pending_words_q.size();
    end
  end

endmodule

/* dv/goldbach_pair_search_top_tb.sv */
// testbench top for goldbach_pair_search_top
// drives test values and window settings, gives the verdict; checking is in gps_result_checker
// depends on gps_pkg, gps_result_checker and the block itself
module goldbach_pair_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gps_pkg::*;

  typedef enum int {
    WIN_WIDE,
    WIN_NARROW,
    WIN_LOW_HALF
  } window_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [FIELD_BITS-1:0] test_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  found_o;
  logic [FIELD_BITS-1:0] first_prime_o;
  logic [FIELD_BITS-1:0] second_prime_o;
  logic [COUNT_BITS-1:0] tested_total_o;
  logic [COUNT_BITS-1:0] success_total_o;
  logic [COUNT_BITS-1:0] failure_total_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  bit          tx_steady = 1'b0;
  int          hold_len = 0;

  goldbach_pair_search_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .test_value_i    (test_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .first_prime_o   (first_prime_o),
    .second_prime_o  (second_prime_o),
    .tested_total_o  (tested_total_o),
    .success_total_o (success_total_o),
    .failure_total_o (failure_total_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  gps_result_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .test_value_i    (test_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_i         (found_o),
    .first_prime_i   (first_prime_o),
    .second_prime_i  (second_prime_o),
    .tested_total_i  (tested_total_o),
    .success_total_i (success_total_o),
    .failure_total_i (failure_total_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending_cnt)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // hard stop; a full-window sweep of a large odd value is slow, so windows
  // are chosen to keep most words quick
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall per word, one long hold on request
  initial begin
    int n;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // offer one test value word, wait until taken
  task automatic send_value(input logic [FIELD_BITS-1:0] v);
    int gap;
    if (tx_steady) gap = 0;
    else gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    test_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // two-phase register access, upper write bits random
  task automatic reg_access(input logic idx, input logic wr, input logic [FIELD_BITS-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom_range(0, 65535)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stop offering, let every result drain, then set and read back the window
  task automatic set_window(input logic [FIELD_BITS-1:0] lo, input logic [FIELD_BITS-1:0] hi);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    reg_access(REG_WINDOW_LOW, 1'b1, lo);
    reg_access(REG_WINDOW_HIGH, 1'b1, hi);
    reg_access(REG_WINDOW_LOW, 1'b0, '0);
    reg_access(REG_WINDOW_HIGH, 1'b0, '0);
  endtask

  // one random window and a run of test values suited to it
  task automatic random_phase(input window_kind_e kind, input int count);
    int unsigned lo;
    int unsigned hi;
    int unsigned v;
    int          i;
    case (kind)
      WIN_WIDE: begin
        lo = $urandom_range(0, 3);
        hi = 65535 - $urandom_range(0, 1000);
      end
      WIN_NARROW: begin
        lo = $urandom_range(2, 30000);
        hi = lo + $urandom_range(0, 128);
      end
      default: begin
        lo = $urandom_range(0, 100);
        hi = $urandom_range(lo, 2000);
      end
    endcase
    set_window(lo[FIELD_BITS-1:0], hi[FIELD_BITS-1:0]);
    for (i = 0; i < count; i++) begin
      case (kind)
        WIN_WIDE: begin
          // mostly even values; small odd ones keep the full sweep short
          if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 150) * 2 + 1;
          else v = $urandom_range(2, 32767) * 2;
        end
        WIN_NARROW: begin
          if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 65535);
          else v = $urandom_range(lo, hi) * 2;
        end
        default: begin
          // above twice the window no partner fits
          if ($urandom_range(0, 1) == 0) v = $urandom_range(lo, hi) * 2;
          else v = $urandom_range(2 * hi + 1, 65535);
        end
      endcase
      send_value(v[FIELD_BITS-1:0]);
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [FIELD_BITS-1:0] reset_win_vals[] = '{16'd4, 16'd6, 16'd8, 16'd0, 16'd1,
                                                 16'd2, 16'd3, 16'd5, 16'd11, 16'd9,
                                                 16'd100, 16'd1024, 16'd65534, 16'd32768};
    int i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window values read back
    reg_access(REG_WINDOW_LOW, 1'b0, '0);
    reg_access(REG_WINDOW_HIGH, 1'b0, '0);

    // reset window: tiny, odd and even extremes
    foreach (reset_win_vals[k]) send_value(reset_win_vals[k]);

    // widest window
    set_window(16'd0, 16'hFFFF);
    send_value(16'd0);
    send_value(16'd1);
    send_value(16'd4);
    send_value(16'd30000);
    send_value(16'd65534);

    // single-value windows at both ends
    set_window(16'hFFFF, 16'hFFFF);
    send_value(16'hFFFF);
    send_value(16'd65534);
    set_window(16'd0, 16'd0);
    send_value(16'd0);
    send_value(16'hFFFF);

    // empty window, fast words; receiver holds off so the block backs up
    set_window(16'd40000, 16'd100);
    tx_steady = 1'b1;
    hold_len = 400;
    for (i = 0; i < 16; i++) send_value(16'($urandom_range(0, 65535)));
    tx_steady = 1'b0;

    // random windows
    random_phase(WIN_WIDE, 14);
    random_phase(WIN_NARROW, 14);
    random_phase(WIN_LOW_HALF, 14);
    random_phase(WIN_NARROW, 14);
    random_phase(WIN_WIDE, 14);
    random_phase(WIN_LOW_HALF, 14);

    // drain and settle
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (100) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
